// ===== src/bc_pkg.sv =====
`timescale 1ns / 1ps
package bc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CAL_A = 2'd0;
  localparam logic [1:0] CFG_CAL_B = 2'd1;
  localparam logic [1:0] CFG_CAL_C = 2'd2;
  localparam logic [1:0] CFG_OSS   = 2'd3;

  // Compensation constants
  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] P_K1      = 32'd3038;
  localparam logic [31:0] P_K2      = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_K3      = 32'd3791;
  localparam logic [31:0] ROUND_T   = 32'd8;
  localparam logic [31:0] ROUND_X3  = 32'd2;
  localparam logic signed [31:0] T_MIN = -32'sd400;
  localparam logic signed [31:0] T_MAX = 32'sd850;
  localparam logic signed [31:0] P_MAX = 32'sd131071;

  // Calibration words unpacked from the registers
  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  // Transaction passed from front to back
  typedef struct packed {
    logic [31:0] b5;
    logic [18:0] up;
    logic        fault;
  } mid_item_t;

  typedef struct packed {
    logic [10:0] temperature_tenths;
    logic [16:0] pressure_pa;
    logic        div_fault;
  } result_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_DEN, F_DIV, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SQ, B_B2, B_AC2, B_AC3, B_B1, B_AC4, B_B7,
    B_DIVS, B_DIV, B_PSQ, B_K1, B_K2, B_FIN, B_OUT
  } back_state_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    return 32'($signed(v) >>> n);
  endfunction

endpackage

// ===== src/bc_div.sv =====
`timescale 1ns / 1ps
// Unsigned 32 / 32 divider, four quotient bits per cycle.
module bc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [2:0]  cnt;
  logic        running;
  logic [31:0] rem_next;
  logic [31:0] quo_next;

  // Four restoring steps
  always_comb begin
    logic [32:0] r;
    logic [31:0] q;
    r = {1'b0, rem};
    q = quo;
    for (int i = 0; i < 4; i++) begin
      r = {r[31:0], q[31]};
      q = {q[30:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q[0] = 1'b1;
      end
    end
    rem_next = r[31:0];
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '1;
        rem     <= '0;
        quo     <= num;
        dvs     <= den;
      end else if (running) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/bc_mid_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module bc_mid_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  bc_pkg::mid_item_t   wr_item,
  output logic                q_full,
  input  logic                rd_en,
  output bc_pkg::mid_item_t   rd_item,
  output logic                q_empty
);

  bc_pkg::mid_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/bc_front.sv =====
`timescale 1ns / 1ps
// Front: input holding register and temperature path up to b5.
module bc_front (
  input  logic              clk,
  input  logic              rst,
  input  bc_pkg::cal_t      cal,
  input  logic              push,
  output logic              full,
  input  logic [15:0]       raw_temperature,
  input  logic [18:0]       raw_pressure,
  output logic              mid_push,
  output bc_pkg::mid_item_t mid_item,
  input  logic              mid_full
);

  bc_pkg::front_state_t state, state_next;

  logic        hold_valid;
  logic [15:0] hold_ut;
  logic [18:0] hold_up;
  logic [15:0] ut;
  logic [18:0] up;
  logic [31:0] prod;
  logic [31:0] x1;
  logic        q_neg;
  logic        fault;
  logic [31:0] b5;

  logic [31:0] x1_c;
  logic [31:0] den_c;
  logic [31:0] num_c;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;
  logic [31:0] num_mag;
  logic [31:0] den_mag;

  assign full = hold_valid;

  // Divisor and dividend for (mc << 11) / (x1 + md)
  assign x1_c    = bc_pkg::asr(prod, 5'd15);
  assign den_c   = x1_c + bc_pkg::sx16(cal.md);
  assign num_c   = {{5{cal.mc[15]}}, cal.mc, 11'b0};
  assign num_mag = num_c[31] ? (32'd0 - num_c) : num_c;
  assign den_mag = den_c[31] ? (32'd0 - den_c) : den_c;

  bc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_mag),
    .den   (den_mag),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bc_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mid_push   = 1'b0;
    case (state)
      bc_pkg::F_IDLE: begin
        if (hold_valid) state_next = bc_pkg::F_MUL;
      end
      bc_pkg::F_MUL: state_next = bc_pkg::F_DEN;
      bc_pkg::F_DEN: begin
        if (den_c == 32'd0) begin
          state_next = bc_pkg::F_PUSH;
        end else begin
          div_start  = 1'b1;
          state_next = bc_pkg::F_DIV;
        end
      end
      bc_pkg::F_DIV: begin
        if (div_done) state_next = bc_pkg::F_PUSH;
      end
      bc_pkg::F_PUSH: begin
        if (!mid_full) begin
          mid_push   = 1'b1;
          state_next = bc_pkg::F_IDLE;
        end
      end
      default: state_next = bc_pkg::F_IDLE;
    endcase
  end

  // Holding register frees as soon as the working copy is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (push && !hold_valid) begin
      hold_valid <= 1'b1;
    end else if (state == bc_pkg::F_IDLE) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !hold_valid) begin
      hold_ut <= raw_temperature;
      hold_up <= raw_pressure;
    end
  end

  // Temperature datapath
  always_ff @(posedge clk) begin
    case (state)
      bc_pkg::F_IDLE: begin
        ut <= hold_ut;
        up <= hold_up;
      end
      bc_pkg::F_MUL: begin
        prod <= 32'(({16'd0, ut} - {16'd0, cal.ac6}) * {16'd0, cal.ac5});
      end
      bc_pkg::F_DEN: begin
        x1    <= x1_c;
        q_neg <= num_c[31] ^ den_c[31];
        fault <= (den_c == 32'd0);
        b5    <= '0;
      end
      bc_pkg::F_DIV: begin
        if (div_done) begin
          b5 <= x1 + (q_neg ? (32'd0 - div_quo) : div_quo);
        end
      end
      default: ;
    endcase
  end

  assign mid_item = '{b5: b5, up: up, fault: fault};

endmodule

// ===== src/bc_back.sv =====
`timescale 1ns / 1ps
// Back: pressure path, saturation and result queue.
module bc_back (
  input  logic              clk,
  input  logic              rst,
  input  bc_pkg::cal_t      cal,
  input  logic              mid_empty,
  input  bc_pkg::mid_item_t mid_item,
  output logic              mid_pop,
  output logic              empty,
  input  logic              pop,
  output bc_pkg::result_t   result
);

  bc_pkg::back_state_t state, state_next;

  logic [31:0] b5;
  logic [18:0] up;
  logic [31:0] b6;
  logic [31:0] sq;
  logic [31:0] x1;
  logic [31:0] b3;
  logic [31:0] b4;
  logic        b7_hi;
  logic [31:0] p;
  logic [31:0] prod;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  bc_pkg::result_t res;

  logic [31:0] b3_v;
  logic [31:0] x3_a;
  logic [31:0] x3_b;
  logic [31:0] p_fin;
  logic [31:0] t_w;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;
  logic [31:0] div_num;
  logic        res_push;

  // Result queue
  bc_pkg::result_t rq [2];
  logic       rq_wr;
  logic       rq_rd;
  logic [1:0] rq_count;
  logic       rq_pop;

  assign empty  = (rq_count == 2'd0);
  assign result = rq[rq_rd];
  assign rq_pop = pop && !empty;

  // Shared multiplier operand select
  always_comb begin
    mul_a = b6;
    mul_b = b6;
    case (state)
      bc_pkg::B_SQ:  begin mul_a = b6; mul_b = b6; end
      bc_pkg::B_B2:  begin mul_a = bc_pkg::sx16(cal.b2); mul_b = bc_pkg::asr(prod, 5'd12); end
      bc_pkg::B_AC2: begin mul_a = bc_pkg::sx16(cal.ac2); mul_b = b6; end
      bc_pkg::B_AC3: begin mul_a = bc_pkg::sx16(cal.ac3); mul_b = b6; end
      bc_pkg::B_B1:  begin mul_a = bc_pkg::sx16(cal.b1); mul_b = sq; end
      bc_pkg::B_AC4: begin mul_a = {16'd0, cal.ac4}; mul_b = x3_b + bc_pkg::B4_BIAS; end
      bc_pkg::B_B7:  begin
        mul_a = {13'd0, up} - b3;
        mul_b = bc_pkg::B7_SCALE >> cal.oss;
      end
      bc_pkg::B_PSQ: begin mul_a = bc_pkg::asr(p, 5'd8); mul_b = bc_pkg::asr(p, 5'd8); end
      bc_pkg::B_K1:  begin mul_a = prod; mul_b = bc_pkg::P_K1; end
      bc_pkg::B_K2:  begin mul_a = p; mul_b = bc_pkg::P_K2; end
      default: ;
    endcase
  end

  // b3 with a truncating divide by four
  always_comb begin
    logic [31:0] v;
    x3_a = x1 + bc_pkg::asr(prod, 5'd11);
    v    = (({cal.ac1[15], cal.ac1[15], cal.ac1[15], cal.ac1[15],
              cal.ac1[15], cal.ac1[15], cal.ac1[15], cal.ac1[15],
              cal.ac1[15], cal.ac1[15], cal.ac1[15], cal.ac1[15],
              cal.ac1[15], cal.ac1[15], cal.ac1, 2'b00} + x3_a) << cal.oss)
           + bc_pkg::ROUND_X3;
    b3_v = bc_pkg::asr(v + (v[31] ? 32'd3 : 32'd0), 5'd2);
  end

  assign x3_b    = bc_pkg::asr(x1 + bc_pkg::asr(prod, 5'd16) + bc_pkg::ROUND_X3, 5'd2);
  assign div_num = prod[31] ? prod : {prod[30:0], 1'b0};
  assign p_fin   = p + bc_pkg::asr(x1 + bc_pkg::asr(prod, 5'd16) + bc_pkg::P_K3, 5'd4);
  assign t_w     = bc_pkg::asr(b5 + bc_pkg::ROUND_T, 5'd4);

  bc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (b4),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mid_pop    = 1'b0;
    div_start  = 1'b0;
    res_push   = 1'b0;
    case (state)
      bc_pkg::B_IDLE: begin
        if (!mid_empty) begin
          mid_pop    = 1'b1;
          state_next = mid_item.fault ? bc_pkg::B_OUT : bc_pkg::B_SQ;
        end
      end
      bc_pkg::B_SQ:  state_next = bc_pkg::B_B2;
      bc_pkg::B_B2:  state_next = bc_pkg::B_AC2;
      bc_pkg::B_AC2: state_next = bc_pkg::B_AC3;
      bc_pkg::B_AC3: state_next = bc_pkg::B_B1;
      bc_pkg::B_B1:  state_next = bc_pkg::B_AC4;
      bc_pkg::B_AC4: state_next = bc_pkg::B_B7;
      bc_pkg::B_B7: begin
        state_next = ((prod >> 15) == 32'd0) ? bc_pkg::B_OUT : bc_pkg::B_DIVS;
      end
      bc_pkg::B_DIVS: begin
        div_start  = 1'b1;
        state_next = bc_pkg::B_DIV;
      end
      bc_pkg::B_DIV: begin
        if (div_done) state_next = bc_pkg::B_PSQ;
      end
      bc_pkg::B_PSQ: state_next = bc_pkg::B_K1;
      bc_pkg::B_K1:  state_next = bc_pkg::B_K2;
      bc_pkg::B_K2:  state_next = bc_pkg::B_FIN;
      bc_pkg::B_FIN: state_next = bc_pkg::B_OUT;
      bc_pkg::B_OUT: begin
        if (rq_count != 2'd2) begin
          res_push   = 1'b1;
          state_next = bc_pkg::B_IDLE;
        end
      end
      default: state_next = bc_pkg::B_IDLE;
    endcase
  end

  // Pressure datapath
  always_ff @(posedge clk) begin
    prod <= 32'(mul_a * mul_b);
    case (state)
      bc_pkg::B_IDLE: begin
        b5  <= mid_item.b5;
        up  <= mid_item.up;
        b6  <= mid_item.b5 - bc_pkg::B6_OFFSET;
        res <= '{temperature_tenths: 11'd0, pressure_pa: 17'd0, div_fault: 1'b1};
      end
      bc_pkg::B_B2:  sq <= bc_pkg::asr(prod, 5'd12);
      bc_pkg::B_AC2: x1 <= bc_pkg::asr(prod, 5'd11);
      bc_pkg::B_AC3: b3 <= b3_v;
      bc_pkg::B_B1:  x1 <= bc_pkg::asr(prod, 5'd13);
      bc_pkg::B_B7:  b4 <= prod >> 15;
      bc_pkg::B_DIVS: b7_hi <= prod[31];
      bc_pkg::B_DIV: begin
        if (div_done) p <= b7_hi ? {div_quo[30:0], 1'b0} : div_quo;
      end
      bc_pkg::B_K2: x1 <= bc_pkg::asr(prod, 5'd16);
      bc_pkg::B_FIN: begin
        res.div_fault <= 1'b0;
        if ($signed(t_w) < bc_pkg::T_MIN) begin
          res.temperature_tenths <= 11'(bc_pkg::T_MIN);
        end else if ($signed(t_w) > bc_pkg::T_MAX) begin
          res.temperature_tenths <= 11'(bc_pkg::T_MAX);
        end else begin
          res.temperature_tenths <= t_w[10:0];
        end
        if (p_fin[31]) begin
          res.pressure_pa <= 17'd0;
        end else if ($signed(p_fin) > bc_pkg::P_MAX) begin
          res.pressure_pa <= 17'(bc_pkg::P_MAX);
        end else begin
          res.pressure_pa <= p_fin[16:0];
        end
      end
      default: ;
    endcase
  end

  // Result queue storage and pointers
  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= '0;
    end else begin
      if (res_push) rq_wr <= ~rq_wr;
      if (rq_pop)   rq_rd <= ~rq_rd;
      case ({res_push, rq_pop})
        2'b10:   rq_count <= rq_count + 2'd1;
        2'b01:   rq_count <= rq_count - 2'd1;
        default: rq_count <= rq_count;
      endcase
    end
  end

endmodule

// ===== src/barometric_compensation_top.sv =====
`timescale 1ns / 1ps
// A zero temperature divisor or zero b4 skips that divide and yields a div_fault result.
// The back-end sequencer (shared 32x32 multiplier plus the b7/b4 divider) sets the
// transaction rate; the front has the shorter sequence.
// The front (b5 path with its own divider) overlaps the back through a 2-entry queue.
// Reset: synchronous, active high; empties queues and clears control state and config.
module barometric_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] raw_temperature,
  input  logic [18:0] raw_pressure,
  output logic        empty,
  input  logic        pop,
  output logic signed [10:0] temperature_tenths,
  output logic [16:0] pressure_pa,
  output logic        div_fault,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] cal_block_a;
  logic [63:0] cal_block_b;
  logic [31:0] cal_block_c;
  logic [1:0]  oversampling;
  bc_pkg::cal_t      cal;
  logic              mid_push;
  logic              mid_pop;
  logic              mid_full;
  logic              mid_empty;
  bc_pkg::mid_item_t mid_wr;
  bc_pkg::mid_item_t mid_rd;
  bc_pkg::result_t   result;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_block_a  <= '0;
      cal_block_b  <= '0;
      cal_block_c  <= '0;
      oversampling <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bc_pkg::CFG_CAL_A: cal_block_a  <= cfg_data;
        bc_pkg::CFG_CAL_B: cal_block_b  <= cfg_data;
        bc_pkg::CFG_CAL_C: cal_block_c  <= cfg_data[31:0];
        bc_pkg::CFG_OSS:   oversampling <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign cal = '{ac1: cal_block_a[63:48], ac2: cal_block_a[47:32],
                 ac3: cal_block_a[31:16], ac4: cal_block_a[15:0],
                 ac5: cal_block_b[63:48], ac6: cal_block_b[47:32],
                 b1:  cal_block_b[31:16], b2:  cal_block_b[15:0],
                 mc:  cal_block_c[31:16], md:  cal_block_c[15:0],
                 oss: oversampling};

  bc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .push            (push),
    .full            (full),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .mid_push        (mid_push),
    .mid_item        (mid_wr),
    .mid_full        (mid_full)
  );

  bc_mid_queue u_mid (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_item (mid_wr),
    .q_full  (mid_full),
    .rd_en   (mid_pop),
    .rd_item (mid_rd),
    .q_empty (mid_empty)
  );

  bc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .mid_empty (mid_empty),
    .mid_item  (mid_rd),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign temperature_tenths = result.temperature_tenths;
  assign pressure_pa        = result.pressure_pa;
  assign div_fault          = result.div_fault;

endmodule
